// File: rtl/core/rsas_pkg.sv
// Shared types, codes and defaults for the rotated sorted array search block.
package rsas_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int WORD_BITS_DEF = 32;
	localparam int VALUE_BITS    = 32;
	localparam int POS_BITS      = 10;
	localparam int OP_BITS       = 2;

	localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_SEARCH = 2'd2;

	typedef struct packed {
		logic [OP_BITS-1:0]           op;
		logic signed [VALUE_BITS-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic                found;
		logic [POS_BITS-1:0] position;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOP,
		ST_FETCH,
		ST_EVAL
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic issue_mid;
		logic issue_q;
		logic narrow;
		logic emit_hit;
		logic emit_miss;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_search;
		logic window_empty;
		logic hit;
	} dp_stat_t;

endpackage

// File: rtl/core/rsas_ctrl.sv
// Controller state machine that sequences append, clear and search probes.
module rsas_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rsas_pkg::dp_stat_t stat,
	output rsas_pkg::dp_cmd_t  cmd
);

	rsas_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			rsas_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					if (stat.is_search) begin
						state_d = rsas_pkg::ST_LOOP;
					end
				end
			end
			rsas_pkg::ST_LOOP: begin
				if (stat.window_empty) begin
					cmd.emit_miss = 1'b1;
					state_d       = rsas_pkg::ST_IDLE;
				end else begin
					cmd.issue_mid = 1'b1;
					state_d       = rsas_pkg::ST_FETCH;
				end
			end
			rsas_pkg::ST_FETCH: begin
				cmd.issue_q = 1'b1;
				state_d     = rsas_pkg::ST_EVAL;
			end
			rsas_pkg::ST_EVAL: begin
				if (stat.hit) begin
					cmd.emit_hit = 1'b1;
					state_d      = rsas_pkg::ST_IDLE;
				end else begin
					cmd.narrow = 1'b1;
					state_d    = rsas_pkg::ST_LOOP;
				end
			end
			default: begin
				state_d = rsas_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/rsas_dpath.sv
// Datapath: element memory, count, search window pointers, probe compare, result register.
module rsas_dpath #(
	parameter int CAPACITY  = rsas_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = rsas_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsas_pkg::cmd_item_t  item,
	input  rsas_pkg::dp_cmd_t    cmd,
	output rsas_pkg::dp_stat_t   stat,
	output logic                 done,
	output rsas_pkg::result_t    result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 1;

	logic [WORD_BITS-1:0]       mem [CAPACITY];
	logic [CW-1:0]              count_q;
	logic signed [PW-1:0]       p_q, q_q;
	logic [WORD_BITS-1:0]       t_q;
	logic [AW-1:0]              mid_q;
	logic [WORD_BITS-1:0]       rd_a_q, rd_b_q, vm_q;
	logic                       done_q;
	rsas_pkg::result_t          result_q;

	logic [63:0]                ext_w;
	logic [WORD_BITS-1:0]       key_w;
	logic [PW:0]                sum_w;
	logic [AW-1:0]              mid_w;
	logic signed [PW-1:0]       mid_s;
	logic                       go_low;
	logic [31:0]                mid32_w;

	// Offset-binary key: sign-extend, trim to the word width, flip the sign bit
	always_comb begin
		ext_w                  = {{(64 - rsas_pkg::VALUE_BITS){item.value[rsas_pkg::VALUE_BITS-1]}},
			item.value};
		key_w                  = ext_w[WORD_BITS-1:0];
		key_w[WORD_BITS-1]     = ~key_w[WORD_BITS-1];
	end

	assign sum_w   = {p_q[PW-1], p_q} + {q_q[PW-1], q_q};
	assign mid_w   = sum_w[AW:1];
	assign mid_s   = PW'(mid_q);
	assign mid32_w = 32'(mid_q);

	assign stat.is_search    = (item.op == rsas_pkg::OP_SEARCH);
	assign stat.window_empty = (p_q > q_q);
	assign stat.hit          = (vm_q == t_q);

	// vp in rd_b_q, vq in rd_a_q, vm in vm_q during evaluation
	always_comb begin
		if (rd_b_q < rd_a_q) begin
			go_low = (vm_q > t_q);
		end else if (rd_b_q > vm_q) begin
			go_low = !((t_q > vm_q) && (t_q <= rd_a_q));
		end else begin
			go_low = (t_q >= rd_b_q) && (t_q < vm_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			if (item.op == rsas_pkg::OP_APPEND && count_q < CW'(CAPACITY)) begin
				count_q <= count_q + CW'(1);
			end else if (item.op == rsas_pkg::OP_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.op == rsas_pkg::OP_APPEND && count_q < CW'(CAPACITY)) begin
			mem[count_q[AW-1:0]] <= key_w;
		end
	end

	// Read ports: A takes mid then q, B takes p
	always_ff @(posedge clk) begin
		if (cmd.issue_mid) begin
			rd_a_q <= mem[mid_w];
			rd_b_q <= mem[p_q[AW-1:0]];
		end else if (cmd.issue_q) begin
			rd_a_q <= mem[q_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q <= key_w;
			p_q <= '0;
			q_q <= $signed({1'b0, count_q}) - PW'(1);
		end else if (cmd.narrow) begin
			if (go_low) begin
				q_q <= mid_s - PW'(1);
			end else begin
				p_q <= mid_s + PW'(1);
			end
		end
		if (cmd.issue_mid) begin
			mid_q <= mid_w;
		end
		if (cmd.issue_q) begin
			vm_q <= rd_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_hit | cmd.emit_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hit | cmd.emit_miss) begin
			result_q.found    <= cmd.emit_hit;
			result_q.position <= cmd.emit_hit ? mid32_w[rsas_pkg::POS_BITS-1:0] : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/core/rotated_sorted_array_search.sv
// Top level of the rotated sorted array search block.
//
//  channel | signals             | direction | handshake
//  --------+---------------------+-----------+------------------------------------
//  command | start, busy, cmd    | in        | item taken when start && !busy
//  result  | done, result        | out       | one-cycle strobe, receiver cannot stall
//
// Append, clear and unknown ops leave busy low and the next item can follow at
// once. A search keeps busy high until it hits, or misses after k probes (at most
// floor(log2(count)) + 1, so 11 probes for a full store of 1024); each probe
// passes the states LOOP, FETCH and EVAL and reads three memory words
// through a two-port memory with registered read data.
// The result strobes in the cycle busy drops. Reset clears the count and the
// controller; the element memory is not cleared, only entries below the count are read.
module rotated_sorted_array_search #(
	parameter int CAPACITY  = rsas_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = rsas_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rsas_pkg::cmd_item_t cmd,
	output logic                done,
	output rsas_pkg::result_t   result
);

	rsas_pkg::dp_cmd_t  dp_cmd;
	rsas_pkg::dp_stat_t dp_stat;

	// Sequence the probes: check window, fetch mid and p, fetch q, evaluate
	rsas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (dp_stat),
		.cmd    (dp_cmd)
	);

	// Hold the store, the window and the registered result
	rsas_dpath #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.done   (done),
		.result (result)
	);

endmodule

// File: rtl/core/rsas_check.sv
// Port-level checker for the rotated sorted array search block, with its bind.
module rsas_check (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input rsas_pkg::cmd_item_t cmd,
	input logic                done,
	input rsas_pkg::result_t   result
);

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.position == '0)
		else $error("miss result with nonzero position");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe without a finishing search");

	a_search_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op == rsas_pkg::OP_SEARCH |=> busy)
		else $error("search item did not start work");

	a_other_op_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op != rsas_pkg::OP_SEARCH |=> !busy && !done)
		else $error("non-search item caused work or a result");

endmodule

bind rotated_sorted_array_search rsas_check u_rsas_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);
